@@ rtl/core/isrch_pkg.sv @@
`timescale 1ns / 1ps

package isrch_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int POS_W         = IDX_W + 1;
   localparam int CNT_W         = $clog2(IDX_W + 1);
   localparam int KEY_W         = 64;
   localparam int ENTRY_INDEX_W = 10;
   localparam int COUNT_W       = 11;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_TEST_LO,
      S_TEST_HI,
      S_DIV_SHIFT,
      S_DIV_ADD,
      S_SPLIT,
      S_RD_SPLIT,
      S_TEST_SPLIT,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RD_LO,
      RD_HI,
      RD_SPLIT
   } rd_sel_type;

   typedef enum logic [1:0] {
      RES_LO,
      RES_HI,
      RES_SPLIT,
      RES_EMPTY
   } res_sel_type;

   typedef struct packed {
      logic        start_search;
      logic        write_entry;
      rd_sel_type  rd_sel;
      logic        capture_lov;
      logic        div_load;
      logic        div_shift;
      logic        div_add;
      logic        split_load;
      logic        narrow;
      logic        set_result;
      res_sel_type res_sel;
      logic        rsp_load;
   } isrch_cmd_type;

   typedef struct packed {
      logic span_empty;
      logic key_le_rd;
      logic key_ge_rd;
      logic key_eq_rd;
      logic div_last;
      logic rsp_free;
   } isrch_sts_type;

endpackage

@@ rtl/core/isrch_ctrl.sv @@
`timescale 1ns / 1ps

module isrch_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   input  isrch_pkg::isrch_sts_type sts,
   output isrch_pkg::isrch_cmd_type cmd
);
   import isrch_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_op) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = sts.span_empty ? S_RESULT : S_TEST_LO;
         end
         S_TEST_LO: begin
            state_in = sts.key_le_rd ? S_RESULT : S_TEST_HI;
         end
         S_TEST_HI: begin
            state_in = sts.key_ge_rd ? S_RESULT : S_DIV_SHIFT;
         end
         S_DIV_SHIFT: begin
            state_in = S_DIV_ADD;
         end
         S_DIV_ADD: begin
            state_in = sts.div_last ? S_SPLIT : S_DIV_SHIFT;
         end
         S_SPLIT: begin
            state_in = S_RD_SPLIT;
         end
         S_RD_SPLIT: begin
            state_in = S_TEST_SPLIT;
         end
         S_TEST_SPLIT: begin
            state_in = sts.key_eq_rd ? S_RESULT : S_CHECK;
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_LO;
      cmd.res_sel = RES_EMPTY;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready        = 1'b1;
            cmd.write_entry  = req_valid && !req_op;
            cmd.start_search = req_valid && req_op;
         end
         S_CHECK: begin
            // The low end is read now so that its key is ready next cycle.
            cmd.rd_sel     = RD_LO;
            cmd.set_result = sts.span_empty;
            cmd.res_sel    = RES_EMPTY;
         end
         S_TEST_LO: begin
            cmd.rd_sel      = RD_HI;
            cmd.capture_lov = 1'b1;
            cmd.set_result  = sts.key_le_rd;
            cmd.res_sel     = RES_LO;
         end
         S_TEST_HI: begin
            cmd.set_result = sts.key_ge_rd;
            cmd.res_sel    = RES_HI;
            cmd.div_load   = !sts.key_ge_rd;
         end
         S_DIV_SHIFT: begin
            cmd.div_shift = 1'b1;
         end
         S_DIV_ADD: begin
            cmd.div_add = 1'b1;
         end
         S_SPLIT: begin
            cmd.split_load = 1'b1;
         end
         S_RD_SPLIT: begin
            cmd.rd_sel = RD_SPLIT;
         end
         S_TEST_SPLIT: begin
            cmd.set_result = sts.key_eq_rd;
            cmd.res_sel    = RES_SPLIT;
            cmd.narrow     = !sts.key_eq_rd;
         end
         S_RESULT: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   a_search_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op) |=> !req_ready)
      else $error("input taken while a search is running");

   a_add_follows_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.div_add |-> $past(cmd.div_shift))
      else $error("divider add step without a preceding shift step");

   a_result_into_free_reg: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over an untaken result");

endmodule

@@ rtl/core/isrch_dp.sv @@
`timescale 1ns / 1ps

module isrch_dp (
   input  logic                                      clock,
   input  logic                                      reset,
   input  isrch_pkg::isrch_cmd_type                  cmd,
   output isrch_pkg::isrch_sts_type                  sts,
   input  logic        [isrch_pkg::ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic signed [isrch_pkg::KEY_W-1:0]         req_entry_value,
   input  logic signed [isrch_pkg::KEY_W-1:0]         req_search_key,
   input  logic                                      csr_write_enable,
   input  logic        [isrch_pkg::COUNT_W-1:0]       csr_write_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_found,
   output logic        [isrch_pkg::POS_W-1:0]         rsp_position
);
   import isrch_pkg::*;

   logic        [KEY_W-1:0]   table_mem [TABLE_DEPTH];
   logic signed [KEY_W-1:0]   rd_data_ff;
   logic        [IDX_W-1:0]   rd_addr;

   logic        [COUNT_W-1:0] entry_count_ff;
   logic        [POS_W-1:0]   count_capped;

   logic signed [KEY_W-1:0]   key_ff;
   logic signed [KEY_W-1:0]   lov_ff;
   logic        [POS_W-1:0]   lo_ff,  lo_in;
   logic signed [POS_W-1:0]   hi_ff,  hi_in;
   logic        [IDX_W-1:0]   split_ff;

   logic        [KEY_W-1:0]   num_ff, den_ff, rem_ff, rem_in;
   logic        [IDX_W-1:0]   mul_ff, quo_ff, quo_in;
   logic        [CNT_W-1:0]   cnt_ff;
   logic        [KEY_W:0]     shifted, summed, den_wide;

   logic                      res_found_ff, res_found_in;
   logic        [POS_W-1:0]   res_pos_ff,   res_pos_in;

   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic        [POS_W-1:0]   rsp_position_ff;

   // Table: one write port for write items, one registered read port.
   always_comb begin
      case (cmd.rd_sel)
         RD_LO:    rd_addr = lo_ff[IDX_W-1:0];
         RD_HI:    rd_addr = hi_ff[IDX_W-1:0];
         RD_SPLIT: rd_addr = split_ff;
         default:  rd_addr = lo_ff[IDX_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry && (32'(req_entry_index) < TABLE_DEPTH)) begin
         table_mem[IDX_W'(req_entry_index)] <= req_entry_value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   assign count_capped = (32'(entry_count_ff) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                             : POS_W'(entry_count_ff);

   assign sts.span_empty = $signed({1'b0, lo_ff}) > $signed({hi_ff[POS_W-1], hi_ff});
   assign sts.key_le_rd  = key_ff <= rd_data_ff;
   assign sts.key_ge_rd  = key_ff >= rd_data_ff;
   assign sts.key_eq_rd  = key_ff == rd_data_ff;
   assign sts.div_last   = cnt_ff == '0;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Span bounds. After a failed probe the span shrinks past the probe and the
   // opposite end also moves in by one.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start_search) begin
         lo_in = '0;
         hi_in = $signed(count_capped) - POS_W'(1);
      end else if (cmd.narrow) begin
         if (!sts.key_ge_rd) begin
            hi_in = $signed(POS_W'(split_ff)) - POS_W'(1);
            lo_in = lo_ff + POS_W'(1);
         end else begin
            lo_in = POS_W'(split_ff) + POS_W'(1);
            hi_in = hi_ff - POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.start_search) begin
         key_ff <= req_search_key;
      end
      if (cmd.capture_lov) begin
         lov_ff <= rd_data_ff;
      end
      if (cmd.split_load) begin
         split_ff <= lo_ff[IDX_W-1:0] + quo_ff;
      end
   end

   // Restoring long division of num * mul by den, one quotient bit of mul
   // per shift and add pair. The remainder always stays below den.
   assign den_wide = {1'b0, den_ff};
   assign shifted  = {rem_ff, 1'b0};
   assign summed   = {1'b0, rem_ff} + {1'b0, num_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_load) begin
         rem_in = '0;
         quo_in = '0;
      end else if (cmd.div_shift) begin
         if (shifted >= den_wide) begin
            rem_in = KEY_W'(shifted - den_wide);
            quo_in = IDX_W'(quo_ff << 1) | IDX_W'(1);
         end else begin
            rem_in = shifted[KEY_W-1:0];
            quo_in = IDX_W'(quo_ff << 1);
         end
      end else if (cmd.div_add && mul_ff[cnt_ff]) begin
         if (summed >= den_wide) begin
            rem_in = KEY_W'(summed - den_wide);
            quo_in = quo_ff + IDX_W'(1);
         end else begin
            rem_in = summed[KEY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.div_load) begin
         num_ff <= key_ff - lov_ff;
         den_ff <= rd_data_ff - lov_ff;
         mul_ff <= hi_ff[IDX_W-1:0] - lo_ff[IDX_W-1:0];
         cnt_ff <= CNT_W'(IDX_W - 1);
      end else if (cmd.div_add && (cnt_ff != '0)) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      if (cmd.set_result) begin
         case (cmd.res_sel)
            RES_LO: begin
               res_found_in = sts.key_eq_rd;
               res_pos_in   = lo_ff;
            end
            RES_HI: begin
               res_found_in = sts.key_eq_rd;
               res_pos_in   = sts.key_eq_rd ? POS_W'(hi_ff) : POS_W'(hi_ff) + POS_W'(1);
            end
            RES_SPLIT: begin
               res_found_in = 1'b1;
               res_pos_in   = POS_W'(split_ff);
            end
            default: begin
               res_found_in = 1'b0;
               res_pos_in   = lo_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff    <= res_found_ff;
         rsp_position_ff <= res_pos_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   a_split_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.split_load |=> (({1'b0, split_ff} >= lo_ff) &&
         ($signed({2'b00, split_ff}) < $signed({hi_ff[POS_W-1], hi_ff}))))
      else $error("probe position outside the open span");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_shift || cmd.div_add) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

endmodule

@@ rtl/core/interpolation_search_table.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Transfer when              Payload
// req      in         req_valid && req_ready     req_op, req_entry_index, req_entry_value,
//                                                req_search_key
// rsp      out        rsp_valid && rsp_ready     rsp_found, rsp_position
// csr      in         csr_write_enable           csr_write_data (entry_count)
//
// A write is stored at its transfer. A search tests the span for emptiness, then the low end and the
// high end key; otherwise the divider's shift and add steps, one pair per quotient bit, give a probe
// position, which is read and tested, and a failed probe narrows the span and starts over.
// Reset clears control and entry_count only; table entries are undefined until written.
// req_ready is low from a search transfer until its result enters the output register; a
// finished search waits while that register still holds an untaken response.

module interpolation_search_table (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_op,
   input  logic        [isrch_pkg::ENTRY_INDEX_W-1:0] req_entry_index,
   input  logic signed [isrch_pkg::KEY_W-1:0]         req_entry_value,
   input  logic signed [isrch_pkg::KEY_W-1:0]         req_search_key,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_found,
   output logic        [isrch_pkg::POS_W-1:0]         rsp_position,
   input  logic                                      csr_write_enable,
   input  logic        [isrch_pkg::COUNT_W-1:0]       csr_write_data
);
   import isrch_pkg::*;

   isrch_cmd_type cmd;
   isrch_sts_type sts;

   isrch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   isrch_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_search_key   (req_search_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position)
   );

endmodule

@@ verif/interpolation_search_table_tb.sv @@
`timescale 1ns / 1ps

module interpolation_search_table_tb;
   import isrch_pkg::TABLE_DEPTH;
   import isrch_pkg::KEY_W;
   import isrch_pkg::POS_W;
   import isrch_pkg::COUNT_W;
   import isrch_pkg::ENTRY_INDEX_W;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam longint KEY_MIN = 64'sh8000_0000_0000_0000;
   localparam longint KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   // A search over a full table can take a few hundred probes in the worst case.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {
      FILL_SPREAD,
      FILL_DUPS,
      FILL_SKEWED,
      FILL_RAMP,
      FILL_SHUFFLED
   } fill_kind_type;

   typedef struct {
      logic                           op;
      logic [ENTRY_INDEX_W-1:0]       index;
      logic signed [KEY_W-1:0]        value;
      logic signed [KEY_W-1:0]        key;
      bit                             drain_first;
   } table_req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } lookup_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_op = OP_WRITE;
   logic        [ENTRY_INDEX_W-1:0] req_entry_index = '0;
   logic signed [KEY_W-1:0]         req_entry_value = '0;
   logic signed [KEY_W-1:0]         req_search_key = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_found;
   logic        [POS_W-1:0]         rsp_position;
   logic                            csr_write_enable = 1'b0;
   logic        [COUNT_W-1:0]       csr_write_data = '0;

   table_req_type           req_backlog[$];
   lookup_type              lookups_due[$];
   logic signed [KEY_W-1:0] key_mirror [TABLE_DEPTH];
   logic [COUNT_W-1:0]      entry_limit = '0;
   longint                  staged [TABLE_DEPTH];

   int unsigned req_queued = 0;
   int unsigned req_offered = 0;
   int unsigned req_accepts = 0;
   int unsigned cycle_count = 0;
   int          errors = 0;
   int          burst_left = 1;
   int          gap_left = 0;
   int          stall_mode = 0;
   int          stall_run = 0;
   table_req_type next_req;
   lookup_type    due;

   interpolation_search_table dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_search_key   (req_search_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic lookup_type predict_lookup(input logic signed [KEY_W-1:0] key);
      lookup_type              res;
      int                      n;
      int                      lo;
      int                      hi;
      int                      split;
      logic signed [KEY_W-1:0] lo_key;
      logic signed [KEY_W-1:0] hi_key;
      logic signed [KEY_W-1:0] mid_key;
      logic [KEY_W-1:0]        gap_num;
      logic [KEY_W-1:0]        gap_den;
      logic [2*KEY_W-1:0]      wide;
      n = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit);
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         lo_key = key_mirror[lo];
         hi_key = key_mirror[hi];
         if (key <= lo_key) begin
            res.found = (key == lo_key);
            res.position = POS_W'(lo);
            return res;
         end
         if (key >= hi_key) begin
            res.found = (key == hi_key);
            res.position = POS_W'(res.found ? hi : hi + 1);
            return res;
         end
         // Both differences are positive here, so their unsigned forms are exact.
         gap_num = key - lo_key;
         gap_den = hi_key - lo_key;
         wide = (2*KEY_W)'(gap_num);
         wide = wide * (2*KEY_W)'(hi - lo);
         wide = wide / gap_den;
         split = lo + int'(wide);
         mid_key = key_mirror[split];
         if (key == mid_key) begin
            res.found = 1'b1;
            res.position = POS_W'(split);
            return res;
         end else if (key < mid_key) begin
            hi = split - 1;
            lo = lo + 1;
         end else begin
            lo = split + 1;
            hi = hi - 1;
         end
      end
      res.found = 1'b0;
      res.position = POS_W'(lo);
      return res;
   endfunction

   // Sender: bursts of transfers separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepts == req_offered) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 &&
                      !(req_backlog[0].drain_first && lookups_due.size() != 0)) begin
            next_req = req_backlog.pop_front();
            req_op <= next_req.op;
            req_entry_index <= next_req.index;
            req_entry_value <= next_req.value;
            req_search_key <= next_req.key;
            req_valid <= 1'b1;
            req_offered = req_offered + 1;
            if (burst_left > 1) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stretches of always ready, random stalls and heavy stalls.
   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run = $urandom_range(20, 200);
      end else begin
         stall_run = stall_run - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   // Monitor: a response is checked before a search accepted at the same edge
   // adds its own expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
               $display("%0t: response with none expected: found %0b position %0d",
                        $time, rsp_found, rsp_position);
               errors = errors + 1;
            end else begin
               due = lookups_due.pop_front();
               if (rsp_found !== due.found) begin
                  $display("%0t: found mismatch: expected %0b actual %0b",
                           $time, due.found, rsp_found);
                  errors = errors + 1;
               end
               if (rsp_position !== due.position) begin
                  $display("%0t: position mismatch: expected %0d actual %0d",
                           $time, due.position, rsp_position);
                  errors = errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_accepts = req_accepts + 1;
            if (req_op == OP_WRITE) begin
               key_mirror[req_entry_index] = req_entry_value;
            end else begin
               lookups_due.push_back(predict_lookup(req_search_key));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_write(input int idx, input longint value);
      table_req_type item;
      item.op = OP_WRITE;
      item.index = ENTRY_INDEX_W'(idx);
      item.value = value;
      item.key = {$urandom, $urandom};
      item.drain_first = 1'b0;
      staged[idx] = value;
      req_backlog.push_back(item);
      req_queued = req_queued + 1;
   endtask

   task automatic queue_search(input longint key, input bit drain_first);
      table_req_type item;
      item.op = OP_SEARCH;
      item.index = ENTRY_INDEX_W'($urandom);
      item.value = {$urandom, $urandom};
      item.key = key;
      item.drain_first = drain_first;
      req_backlog.push_back(item);
      req_queued = req_queued + 1;
   endtask

   // Waits until every transfer is done and every response is in, then lets a
   // write that gives no response finish.
   task automatic settle();
      do begin
         @(negedge clock);
      end while (req_accepts != req_queued || lookups_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_count(input int count);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= COUNT_W'(count);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      entry_limit = COUNT_W'(count);
   endtask

   task automatic fill_table(input int n, input fill_kind_type kind);
      longint vals[$];
      longint base;
      longint step;
      int     i;
      base = -longint'($urandom_range(0, 100000));
      step = longint'($urandom_range(1, 1000000));
      for (i = 0; i < n; i++) begin
         case (kind)
            FILL_DUPS: begin
               vals.push_back(longint'($urandom_range(0, 6)) - 3);
            end
            FILL_SKEWED: begin
               vals.push_back((longint'(1) << $urandom_range(0, 62)) +
                              longint'($urandom_range(0, 3)));
            end
            FILL_RAMP: begin
               vals.push_back(base + i * step);
            end
            default: begin
               vals.push_back({$urandom, $urandom});
            end
         endcase
      end
      // A shuffled table stays out of order; the search still has a defined answer.
      if (kind != FILL_SHUFFLED) begin
         vals.sort();
      end
      for (i = 0; i < n; i++) begin
         queue_write(i, vals[i]);
      end
   endtask

   function automatic longint pick_key(input int n);
      int     sel;
      longint v;
      sel = $urandom_range(0, 9);
      v = staged[(n > 0) ? $urandom_range(0, n - 1) : 0];
      if (sel < 4) begin
         return v;
      end else if (sel < 6) begin
         return v + 1;
      end else if (sel < 8) begin
         return v - 1;
      end else if (sel == 8) begin
         return {$urandom, $urandom};
      end
      return ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
   endfunction

   initial begin
      int            p;
      int            j;
      int            n;
      fill_kind_type kind;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, single entry, and full-range keys.
      queue_search(5, 1'b0);
      queue_write(0, KEY_MIN);
      queue_write(1, -100);
      queue_write(2, 50);
      queue_write(3, KEY_MAX);
      queue_write(TABLE_DEPTH - 1, KEY_MAX);
      load_count(1);
      queue_search(KEY_MIN, 1'b0);
      queue_search(KEY_MIN + 1, 1'b0);
      queue_search(KEY_MAX, 1'b0);
      load_count(4);
      queue_search(KEY_MIN, 1'b0);
      queue_search(KEY_MAX, 1'b0);
      queue_search(-100, 1'b0);
      queue_search(50, 1'b0);
      queue_search(0, 1'b0);
      queue_search(-101, 1'b0);
      queue_search(51, 1'b0);
      queue_search(KEY_MAX - 1, 1'b0);
      load_count(0);
      for (j = 0; j < 3; j++) begin
         queue_search({$urandom, $urandom}, 1'b0);
      end

      // Full table, then a count above the depth, which is clamped to it.
      fill_table(TABLE_DEPTH, FILL_SPREAD);
      load_count(TABLE_DEPTH);
      for (j = 0; j < 30; j++) begin
         queue_search(pick_key(TABLE_DEPTH), j == 15);
      end
      load_count((1 << COUNT_W) - 1);
      for (j = 0; j < 10; j++) begin
         queue_search(pick_key(TABLE_DEPTH), 1'b0);
      end

      // Small tables of every shape, with stray writes mixed in.
      for (p = 0; p < 5; p++) begin
         n = (p == 0) ? 2 : $urandom_range(2, 12);
         kind = fill_kind_type'(p);
         fill_table(n, kind);
         load_count(n);
         for (j = 0; j < 8; j++) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_write($urandom_range(0, TABLE_DEPTH - 1), {$urandom, $urandom});
            end
            queue_search(pick_key(n), (p == 3 && j == 4) || $urandom_range(0, 29) == 0);
         end
      end

      settle();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
